/* src/rotation_matrix_to_quaternion_assert.svh */
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// implication checked while out of reset
`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// next-cycle implication, reset included
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

`endif

/* src/rmq_pkg.sv */
// shared types and constants for the rotation matrix to quaternion block
package rmq_pkg;

    localparam int DATA_W = 16;

    localparam logic [1:0] CASE_TRACE = 2'd0;
    localparam logic [1:0] CASE_X     = 2'd1;
    localparam logic [1:0] CASE_Y     = 2'd2;
    localparam logic [1:0] CASE_Z     = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] elem_0_0;
        logic signed [DATA_W-1:0] elem_0_1;
        logic signed [DATA_W-1:0] elem_0_2;
        logic signed [DATA_W-1:0] elem_1_0;
        logic signed [DATA_W-1:0] elem_1_1;
        logic signed [DATA_W-1:0] elem_1_2;
        logic signed [DATA_W-1:0] elem_2_0;
        logic signed [DATA_W-1:0] elem_2_1;
        logic signed [DATA_W-1:0] elem_2_2;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] quat_w;
        logic        [1:0]        case_taken;
    } t_out;

endpackage

/* src/rmq_sqrt.sv */
// pipelined integer square root, one result bit per stage, with sideband
module rmq_sqrt import rmq_pkg::*; #(
    parameter int NW  = 32,
    parameter int SBW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [NW-1:0]       i_rad,
    input  logic [SBW-1:0]      i_sb,
    output logic                o_valid,
    output logic [NW/2-1:0]     o_root,
    output logic [SBW-1:0]      o_sb
);
    localparam int SW = NW / 2;

    logic            r_v    [SW+1];
    logic [SW+1:0]   r_rem  [SW+1];
    logic [SW-1:0]   r_root [SW+1];
    logic [NW-1:0]   r_rad  [SW+1];
    logic [SBW-1:0]  r_sb   [SW+1];

    assign r_v[0]    = i_valid;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign r_rad[0]  = i_rad;
    assign r_sb[0]   = i_sb;

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic [SW+1:0] rem_sh;
        logic [SW+1:0] trial;
        logic          ge;
        logic [SW+1:0] n_rem;
        logic [SW-1:0] n_root;

        always_comb begin
            rem_sh = {r_rem[k][SW-1:0], r_rad[k][NW-1:NW-2]};
            trial  = {r_root[k], 2'b01};
            ge     = rem_sh >= trial;
            n_rem  = ge ? rem_sh - trial : rem_sh;
            n_root = {r_root[k][SW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= n_root;
                r_rad[k+1]  <= {r_rad[k][NW-3:0], 2'b00};
                r_sb[k+1]   <= r_sb[k];
            end
        end
    end

    assign o_valid = r_v[SW];
    assign o_root  = r_root[SW];
    assign o_sb    = r_sb[SW];

endmodule

/* src/rmq_div.sv */
// three-lane pipelined restoring divider sharing one divisor, one bit per stage
module rmq_div import rmq_pkg::*; #(
    parameter int NUW = 32,
    parameter int DVW = 17,
    parameter int SBW = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2:0][NUW-1:0]    i_num,
    input  logic [DVW-1:0]         i_den,
    input  logic [SBW-1:0]         i_sb,
    output logic                   o_valid,
    output logic [2:0][NUW-1:0]    o_quo,
    output logic [SBW-1:0]         o_sb
);
    logic                  r_v   [NUW+1];
    logic [2:0][DVW:0]     r_rem [NUW+1];
    logic [2:0][NUW-1:0]   r_x   [NUW+1];
    logic [DVW-1:0]        r_den [NUW+1];
    logic [SBW-1:0]        r_sb  [NUW+1];

    assign r_v[0]   = i_valid;
    assign r_rem[0] = '0;
    assign r_x[0]   = i_num;
    assign r_den[0] = i_den;
    assign r_sb[0]  = i_sb;

    for (genvar k = 0; k < NUW; k++) begin : g_stage
        logic [2:0][DVW:0]   n_rem;
        logic [2:0][NUW-1:0] n_x;

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [DVW:0] rem_sh;
            logic         ge;
            always_comb begin
                rem_sh   = {r_rem[k][l][DVW-1:0], r_x[k][l][NUW-1]};
                ge       = rem_sh >= {1'b0, r_den[k]};
                n_rem[l] = ge ? rem_sh - {1'b0, r_den[k]} : rem_sh;
                n_x[l]   = {r_x[k][l][NUW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1] <= n_rem;
                r_x[k+1]   <= n_x;
                r_den[k+1] <= r_den[k];
                r_sb[k+1]  <= r_sb[k];
            end
        end
    end

    assign o_valid = r_v[NUW];
    assign o_quo   = r_x[NUW];
    assign o_sb    = r_sb[NUW];

endmodule

/* src/rotation_matrix_to_quaternion.sv */
// rotation matrix to quaternion converter: top level pipeline
// pipeline: registers a, b and c, the square root, register d, the divider and output register e
// with the default format the square root gives 16 bits and each quotient 32 bits
// throughput: one item per cycle; the whole pipeline holds while the output waits
// synchronous active-low reset clears all valid bits; data registers are not reset
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);
    localparam int W   = DATA_W;
    localparam int RW  = ((FRAC_BITS + 2 > W) ? FRAC_BITS + 2 : W) + 3;
    localparam int NW0 = RW - 1 + FRAC_BITS;
    localparam int SW  = (NW0 + 1) / 2;
    localparam int NW  = 2 * SW;
    localparam int MW  = W + 1;
    localparam int NUW = MW + FRAC_BITS + 1;
    localparam int DVW = SW + 1;

    localparam logic signed [RW-1:0] ONE = RW'(1) << FRAC_BITS;
    localparam logic [NUW-1:0] POS_MAX = NUW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [NUW-1:0] NEG_MAX = NUW'(64'd1 << (W - 1));
    localparam logic [W-1:0]   SAT_HI  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   SAT_LO  = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][MW-1:0] mag;
        logic [2:0]         neg;
        logic               pos;
        logic [1:0]         kase;
    } t_sb1;

    typedef struct packed {
        logic [2:0]  neg;
        logic        pos;
        logic [1:0]  kase;
        logic [SW-1:0] half;
    } t_sb2;

    function automatic logic signed [RW-1:0] sx(input logic signed [W-1:0] v);
        return RW'(v);
    endfunction

    function automatic logic [W-1:0] sat_q(input logic [NUW-1:0] q, input logic neg);
        logic [NUW-1:0] t;
        t = '0;
        if (neg) begin
            if (q > NEG_MAX) return SAT_LO;
            t = NUW'(0) - q;
            return t[W-1:0];
        end
        if (q > POS_MAX) return SAT_HI;
        return q[W-1:0];
    endfunction

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // stage a: input register
    logic r_a_v;
    t_in  r_a_m;

    // stage b: trace and largest diagonal
    logic                 r_b_v;
    t_in                  r_b_m;
    logic signed [RW-1:0] r_b_trace;
    logic                 r_b_tpos;
    logic [1:0]           r_b_idx;
    logic signed [RW-1:0] n_b_trace;
    logic [1:0]           n_b_idx;

    always_comb begin
        n_b_trace = sx(r_a_m.elem_0_0) + sx(r_a_m.elem_1_1) + sx(r_a_m.elem_2_2);
        n_b_idx   = CASE_X;
        if (r_a_m.elem_1_1 > r_a_m.elem_0_0) n_b_idx = CASE_Y;
        if (r_a_m.elem_2_2 > ((n_b_idx == CASE_Y) ? r_a_m.elem_1_1 : r_a_m.elem_0_0))
            n_b_idx = CASE_Z;
    end

    // stage c: radicand and off-diagonal terms
    logic                 r_c_v;
    logic [NW-1:0]        r_c_rad;
    t_sb1                 r_c_sb;
    logic signed [RW-1:0] rad;
    logic signed [RW-1:0] d [3];
    t_sb1                 n_c_sb;
    logic [RW-1:0]        dabs;

    always_comb begin
        rad  = '0;
        d[0] = '0;
        d[1] = '0;
        d[2] = '0;
        dabs = '0;
        case (r_b_tpos ? CASE_TRACE : r_b_idx)
            CASE_TRACE: begin
                rad  = r_b_trace + ONE;
                d[0] = sx(r_b_m.elem_1_2) - sx(r_b_m.elem_2_1);
                d[1] = sx(r_b_m.elem_2_0) - sx(r_b_m.elem_0_2);
                d[2] = sx(r_b_m.elem_0_1) - sx(r_b_m.elem_1_0);
            end
            CASE_X: begin
                rad  = ONE + sx(r_b_m.elem_0_0) - sx(r_b_m.elem_1_1) - sx(r_b_m.elem_2_2);
                d[0] = sx(r_b_m.elem_0_1) + sx(r_b_m.elem_1_0);
                d[1] = sx(r_b_m.elem_0_2) + sx(r_b_m.elem_2_0);
                d[2] = sx(r_b_m.elem_1_2) - sx(r_b_m.elem_2_1);
            end
            CASE_Y: begin
                rad  = ONE + sx(r_b_m.elem_1_1) - sx(r_b_m.elem_2_2) - sx(r_b_m.elem_0_0);
                d[0] = sx(r_b_m.elem_1_2) + sx(r_b_m.elem_2_1);
                d[1] = sx(r_b_m.elem_1_0) + sx(r_b_m.elem_0_1);
                d[2] = sx(r_b_m.elem_2_0) - sx(r_b_m.elem_0_2);
            end
            default: begin
                rad  = ONE + sx(r_b_m.elem_2_2) - sx(r_b_m.elem_0_0) - sx(r_b_m.elem_1_1);
                d[0] = sx(r_b_m.elem_2_0) + sx(r_b_m.elem_0_2);
                d[1] = sx(r_b_m.elem_2_1) + sx(r_b_m.elem_1_2);
                d[2] = sx(r_b_m.elem_0_1) - sx(r_b_m.elem_1_0);
            end
        endcase
        n_c_sb.pos  = rad > 0;
        n_c_sb.kase = r_b_tpos ? CASE_TRACE : r_b_idx;
        for (int l = 0; l < 3; l++) begin
            n_c_sb.neg[l] = d[l][RW-1];
            dabs          = d[l][RW-1] ? RW'(0) - d[l] : d[l];
            n_c_sb.mag[l] = dabs[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_in_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
        if (en) begin
            r_a_m     <= i_in_data;
            r_b_m     <= r_a_m;
            r_b_trace <= n_b_trace;
            r_b_tpos  <= n_b_trace > 0;
            r_b_idx   <= n_b_idx;
            r_c_sb    <= n_c_sb;
            r_c_rad   <= n_c_sb.pos ? NW'({rad[RW-2:0], {FRAC_BITS{1'b0}}}) : '0;
        end
    end

    // square root
    logic          sq_v;
    logic [SW-1:0] sq_root;
    logic [$bits(t_sb1)-1:0] sq_sb_raw;
    t_sb1          sq_sb;

    rmq_sqrt #(.NW(NW), .SBW($bits(t_sb1))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_v),
        .i_rad   (r_c_rad),
        .i_sb    (r_c_sb),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_sb    (sq_sb_raw)
    );
    assign sq_sb = t_sb1'(sq_sb_raw);

    // stage d: dividends and divisor
    logic                r_d_v;
    logic [2:0][NUW-1:0] r_d_num;
    logic [DVW-1:0]      r_d_den;
    t_sb2                r_d_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= sq_v;
        end
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_d_num[l] <= {1'b0, sq_sb.mag[l], {FRAC_BITS{1'b0}}} + NUW'(sq_root);
            end
            r_d_den       <= {sq_root, 1'b0};
            r_d_sb.neg    <= sq_sb.neg;
            r_d_sb.pos    <= sq_sb.pos;
            r_d_sb.kase   <= sq_sb.kase;
            r_d_sb.half   <= {1'b0, sq_root[SW-1:1]};
        end
    end

    // division
    logic                dv_v;
    logic [2:0][NUW-1:0] dv_quo;
    logic [$bits(t_sb2)-1:0] dv_sb_raw;
    t_sb2                dv_sb;

    rmq_div #(.NUW(NUW), .DVW(DVW), .SBW($bits(t_sb2))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_v),
        .i_num   (r_d_num),
        .i_den   (r_d_den),
        .i_sb    (r_d_sb),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_sb    (dv_sb_raw)
    );
    assign dv_sb = t_sb2'(dv_sb_raw);

    // stage e: saturate and place components
    logic       r_out_v;
    t_out       r_out;
    t_out       n_out;
    logic [W-1:0] q0, q1, q2, hq;

    always_comb begin
        q0 = sat_q(dv_quo[0], dv_sb.neg[0]);
        q1 = sat_q(dv_quo[1], dv_sb.neg[1]);
        q2 = sat_q(dv_quo[2], dv_sb.neg[2]);
        hq = sat_q(NUW'(dv_sb.half), 1'b0);
        n_out = '0;
        n_out.case_taken = dv_sb.kase;
        if (dv_sb.pos) begin
            case (dv_sb.kase)
                CASE_TRACE: begin
                    n_out.quat_x = q0; n_out.quat_y = q1;
                    n_out.quat_z = q2; n_out.quat_w = hq;
                end
                CASE_X: begin
                    n_out.quat_x = hq; n_out.quat_y = q0;
                    n_out.quat_z = q1; n_out.quat_w = q2;
                end
                CASE_Y: begin
                    n_out.quat_y = hq; n_out.quat_z = q0;
                    n_out.quat_x = q1; n_out.quat_w = q2;
                end
                default: begin
                    n_out.quat_z = hq; n_out.quat_x = q0;
                    n_out.quat_y = q1; n_out.quat_w = q2;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_v;
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`include "rotation_matrix_to_quaternion_assert.svh"

    `RMQ_ASSERT_NEXT(a_reset_empty, !i_rst_n, !o_out_valid)
    `RMQ_ASSERT_IMPL(a_w_nonneg, o_out_valid && o_out_data.case_taken == CASE_TRACE, !o_out_data.quat_w[W-1])
    `RMQ_ASSERT_IMPL(a_lead_nonneg, o_out_valid && o_out_data.case_taken == CASE_X, !o_out_data.quat_x[W-1])
    `RMQ_ASSERT_IMPL(a_stall_hold, o_out_valid && !i_out_ready, !o_in_ready)

endmodule
